FILE: rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Types and codes shared by the linear probing hash table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpht_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned KEY_W     = 16;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned SLOT_W    = 4;

  // request codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  // response codes
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  // slot states
  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_USED  = 2'd1;
  localparam logic [1:0] ST_GONE  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
  } rsp_t;

endpackage

FILE: rtl/lpht_front.sv
// ----------------------------------------------------------------------------
// lpht_front
// Accepts requests and works out the home slot, key mod SLOTS, with a
// reciprocal multiply followed by a subtract, then hands it on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpht_front #(
  parameter int unsigned SLOTS = 16,
  localparam int unsigned IdxW = $clog2(SLOTS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clear_busy_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lpht_pkg::req_t               in_data_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output logic [lpht_pkg::OP_W-1:0]    op_o,
  output logic [lpht_pkg::VAL_W-1:0]   item_value_o,
  output logic [IdxW-1:0]              home_o
);

  typedef enum logic [1:0] {
    IDLE,
    MUL,
    SUB,
    PUSH
  } state_e;

  // ceil(2^32 / SLOTS), exact quotient for any 16-bit key
  localparam logic [31:0] Recip =
    32'(((64'd1 << 32) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));
  localparam logic [lpht_pkg::KEY_W-1:0] SlotsK = lpht_pkg::KEY_W'(SLOTS);

  state_e                             state_q;
  logic [lpht_pkg::OP_W-1:0]          op_q;
  logic [lpht_pkg::VAL_W-1:0]         val_q;
  logic [lpht_pkg::KEY_W-1:0]         key_q;
  logic [lpht_pkg::KEY_W-1:0]         quot_q;
  logic [IdxW-1:0]                    rem_q;
  logic [lpht_pkg::KEY_W+31:0]        prod;
  logic [lpht_pkg::KEY_W-1:0]         rem_full;

  assign prod     = key_q * Recip;
  assign rem_full = key_q - quot_q * SlotsK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      quot_q  <= '0;
      rem_q   <= '0;
    end else begin
      case (state_q)
        IDLE: begin
          if (in_valid_i && in_ready_o) begin
            op_q    <= in_data_i.op;
            val_q   <= in_data_i.item_value;
            key_q   <= in_data_i.key;
            state_q <= MUL;
          end
        end
        MUL: begin
          quot_q  <= prod[lpht_pkg::KEY_W+31 -: lpht_pkg::KEY_W];
          state_q <= SUB;
        end
        SUB: begin
          rem_q   <= rem_full[IdxW-1:0];
          state_q <= PUSH;
        end
        PUSH: begin
          if (push_ready_i) begin
            state_q <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign in_ready_o   = (state_q == IDLE) && !clear_busy_i;
  assign push_valid_o = (state_q == PUSH);
  assign op_o         = op_q;
  assign item_value_o = val_q;
  assign home_o       = rem_q;

endmodule

FILE: rtl/lpht_queue.sv
// ----------------------------------------------------------------------------
// lpht_queue
// Two-entry queue between the front and the probe engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpht_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  logic [Width-1:0] entry_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/lpht_back.sv
// ----------------------------------------------------------------------------
// lpht_back
// Probe engine: walks the slot store one slot per cycle from the home slot,
// updates it and drives the registered response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpht_back #(
  parameter int unsigned SLOTS = 16,
  localparam int unsigned IdxW = $clog2(SLOTS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pop_valid_i,
  output logic                         pop_ready_o,
  input  logic [lpht_pkg::OP_W-1:0]    op_i,
  input  logic [lpht_pkg::VAL_W-1:0]   item_value_i,
  input  logic [IdxW-1:0]              home_i,
  output logic                         clear_busy_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lpht_pkg::rsp_t               out_data_o
);

  typedef enum logic [1:0] {
    CLEAR,
    IDLE,
    PROBE
  } state_e;

  state_e                              state_q;
  logic [IdxW-1:0]                     clr_q;
  logic [lpht_pkg::OP_W-1:0]           op_q;
  logic [lpht_pkg::VAL_W-1:0]          val_q;
  logic [IdxW-1:0]                     idx_q;
  logic [IdxW-1:0]                     step_q;
  logic                                out_valid_q;
  lpht_pkg::rsp_t                      out_q;

  logic [1:0]                          st_mem [SLOTS];
  logic [lpht_pkg::VAL_W-1:0]          val_mem [SLOTS];
  logic [1:0]                          st_rd_q;
  logic [lpht_pkg::VAL_W-1:0]          val_rd_q;

  logic [IdxW-1:0]                     idx_inc;
  logic                                last_step;
  logic                                done;
  logic                                st_we;
  logic [1:0]                          st_wdata;
  logic                                val_we;
  logic [lpht_pkg::STATUS_W-1:0]       res_status;
  logic                                term_ok;
  logic                                fire;
  logic [IdxW-1:0]                     rd_addr;
  logic [IdxW-1:0]                     wr_addr;
  logic                                st_wr_en;
  logic [1:0]                          st_wr_data;
  logic [IdxW+lpht_pkg::SLOT_W-1:0]    slot_ext;
  lpht_pkg::rsp_t                      rsp;

  assign idx_inc   = (idx_q == IdxW'(SLOTS - 1)) ? '0 : idx_q + 1'b1;
  assign last_step = (step_q == IdxW'(SLOTS - 1));

  // decision for the slot under test
  always_comb begin
    done       = 1'b0;
    st_we      = 1'b0;
    st_wdata   = lpht_pkg::ST_USED;
    val_we     = 1'b0;
    res_status = lpht_pkg::STATUS_OK;
    case (op_q)
      lpht_pkg::OP_INSERT: begin
        if (st_rd_q != lpht_pkg::ST_USED) begin
          done   = 1'b1;
          st_we  = 1'b1;
          val_we = 1'b1;
        end else if (last_step) begin
          done       = 1'b1;
          res_status = lpht_pkg::STATUS_FULL;
        end
      end
      lpht_pkg::OP_DELETE, lpht_pkg::OP_SEARCH: begin
        if (st_rd_q == lpht_pkg::ST_EMPTY) begin
          done       = 1'b1;
          res_status = lpht_pkg::STATUS_MISS;
        end else if (st_rd_q == lpht_pkg::ST_USED && val_rd_q == val_q) begin
          done = 1'b1;
          if (op_q == lpht_pkg::OP_DELETE) begin
            st_we    = 1'b1;
            st_wdata = lpht_pkg::ST_GONE;
          end
        end else if (last_step) begin
          done       = 1'b1;
          res_status = lpht_pkg::STATUS_MISS;
        end
      end
      default: begin
        done       = 1'b1;
        res_status = lpht_pkg::STATUS_MISS;
      end
    endcase
  end

  assign term_ok = !out_valid_q || out_ready_i;
  assign fire    = (state_q == PROBE) && done && term_ok;

  assign slot_ext   = {{lpht_pkg::SLOT_W{1'b0}}, idx_q};
  assign rsp.status = res_status;
  assign rsp.slot   = (res_status == lpht_pkg::STATUS_OK) ?
                      slot_ext[lpht_pkg::SLOT_W-1:0] : '0;

  always_comb begin
    case (state_q)
      IDLE:    rd_addr = home_i;
      PROBE:   rd_addr = done ? idx_q : idx_inc;
      default: rd_addr = idx_q;
    endcase
  end

  assign wr_addr    = (state_q == CLEAR) ? clr_q : idx_q;
  assign st_wr_en   = (state_q == CLEAR) || (fire && st_we);
  assign st_wr_data = (state_q == CLEAR) ? lpht_pkg::ST_EMPTY : st_wdata;

  // slot state and value stores
  always_ff @(posedge clk_i) begin
    if (st_wr_en) begin
      st_mem[wr_addr] <= st_wr_data;
    end
    st_rd_q <= st_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (fire && val_we) begin
      val_mem[idx_q] <= val_q;
    end
    val_rd_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == IdxW'(SLOTS - 1)) begin
            state_q <= IDLE;
          end
        end
        IDLE: begin
          if (pop_valid_i) begin
            op_q    <= op_i;
            val_q   <= item_value_i;
            idx_q   <= home_i;
            step_q  <= '0;
            state_q <= PROBE;
          end
        end
        PROBE: begin
          if (!done) begin
            idx_q  <= idx_inc;
            step_q <= step_q + 1'b1;
          end else if (term_ok) begin
            state_q <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
      if (fire) begin
        out_valid_q <= 1'b1;
        out_q       <= rsp;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign pop_ready_o  = (state_q == IDLE);
  assign clear_busy_o = (state_q == CLEAR);
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;

endmodule

FILE: rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Probes: each transaction reads 1 to SLOTS slots, one per cycle in the
//   probe engine.
// Flow: the front takes a new transaction only when done with the last
//   (residue by reciprocal multiply); so does the probe engine.
// Reset: a clear pass marks every slot empty; in_ready_o is low meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_probe_hash_table #(
  parameter int unsigned SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lpht_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lpht_pkg::rsp_t out_data_o
);

  localparam int unsigned IdxW   = $clog2(SLOTS);
  localparam int unsigned QWidth = lpht_pkg::OP_W + lpht_pkg::VAL_W + IdxW;

  logic                         clear_busy;
  logic                         push_valid;
  logic                         push_ready;
  logic [lpht_pkg::OP_W-1:0]    f_op;
  logic [lpht_pkg::VAL_W-1:0]   f_val;
  logic [IdxW-1:0]              f_home;
  logic                         pop_valid;
  logic                         pop_ready;
  logic [QWidth-1:0]            q_data;

  lpht_front #(
    .SLOTS(SLOTS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_busy_i (clear_busy),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .op_o         (f_op),
    .item_value_o (f_val),
    .home_o       (f_home)
  );

  lpht_queue #(
    .Width(QWidth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({f_op, f_val, f_home}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (q_data)
  );

  lpht_back #(
    .SLOTS(SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .op_i         (q_data[QWidth-1 -: lpht_pkg::OP_W]),
    .item_value_i (q_data[IdxW +: lpht_pkg::VAL_W]),
    .home_i       (q_data[IdxW-1:0]),
    .clear_busy_o (clear_busy),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
